### hw/rtl/first_fit_free_list_allocator_core_defines.svh
// Assertion macros for the first-fit free-list allocator core.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffa assertion failed");

// Next-cycle implication, disabled while in reset.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffa assertion failed");

`endif

### hw/rtl/ffa_pkg.sv
// Shared types and codes for the first-fit free-list allocator.
`default_nettype none

package ffa_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_ALLOC  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        alloc;
    logic [15:0] start;
    logic [15:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted;
    logic [4:0]  free_count;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/first_fit_free_list_allocator_core.sv
// Each request is taken from the queue with its match registered; the block table is then
// updated when its result is registered. No new request is taken from the queue until
// the current one's result is registered, as both steps share the block table.
// A two-entry request queue keeps accepting, until it is full, while a result waits on the output.
// Reset (synchronous): clears the valid marks, the block count and the queue.
`default_nettype none
`include "first_fit_free_list_allocator_core_defines.svh"

module first_fit_free_list_allocator_core #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // block_start[15:0], amount[31:16]
  input  wire logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // granted_start[15:0], free_count[20:16], zero
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam logic [4:0] FULL_COUNT = 5'(ENTRIES);

  logic          q_valid;
  logic          q_pop;
  ffa_pkg::req_t q_req;
  ffa_pkg::res_t res;

  ffa_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  ffa_back #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {3'd0, res.free_count, res.granted};
  assign m_axis_tuser = res.status;

  `FFA_ASSERT_IMP(a_full_count, m_axis_tvalid && (res.status == ffa_pkg::ST_FULL), res.free_count == FULL_COUNT)
  `FFA_ASSERT_IMP(a_fail_no_grant, m_axis_tvalid && (res.status != ffa_pkg::ST_OK), res.granted == 16'd0)
  `FFA_ASSERT_IMP(a_pop_needs_req, q_pop, q_valid)
  `FFA_ASSERT_NEXT(a_nofit_keeps, q_pop && !q_valid, 1'b0)

endmodule

`default_nettype wire

### hw/rtl/ffa_front.sv
// Request intake: accept, mask and classify items into a two-entry queue.
`default_nettype none

module ffa_front #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // block_start[15:0], amount[31:16]
  input  wire logic [0:0]    s_axis_tuser,   // req_type[0]
  output logic               q_valid,
  output ffa_pkg::req_t      q_req,
  input  wire logic          q_pop
);

  localparam logic [15:0] FIELD_MASK =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << ADDR_BITS) - 33'd1);

  ffa_pkg::req_t slot [2];
  ffa_pkg::req_t in_req;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic          push;

  always_comb begin
    in_req.alloc  = (s_axis_tuser[0] == ffa_pkg::REQ_ALLOC);
    in_req.start  = s_axis_tdata[15:0] & FIELD_MASK;
    in_req.amount = s_axis_tdata[31:16] & FIELD_MASK;
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (cnt != 2'd0);
  assign q_req         = slot[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !q_pop) begin
      cnt_next = cnt + 2'd1;
    end else if (!push && q_pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_req;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ffa_back.sv
// Block table and request execution: match, then insert or remove.
`default_nettype none

module ffa_back #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ffa_pkg::req_t q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffa_pkg::res_t      out_res
);

  localparam int W  = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [W-1:0]       start_q [ENTRIES];
  logic [W-1:0]       size_q  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [CW-1:0]      count;
  logic               exec;
  ffa_pkg::req_t      cur;
  logic [ENTRIES-1:0] match;

  logic               fire;
  logic               full;
  logic               hit;
  logic [ENTRIES-1:0] first;
  logic [ENTRIES-1:0] below;
  logic [W-1:0]       granted;
  logic [CW-1:0]      count_next;
  logic [CW+4:0]      count_wide;
  logic               do_insert;
  logic               do_remove;
  logic [1:0]         status;
  logic [15:0]        granted_ext;

  assign q_pop = q_valid && !exec;
  assign fire  = exec && (!out_valid || out_ready);
  assign full  = (count == CW'(ENTRIES));
  assign hit   = |match;
  assign first = match & (~match + ENTRIES'(1));
  assign below = first - ENTRIES'(1);

  always_comb begin
    granted = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first[i]) begin
        granted = granted | start_q[i];
      end
    end
  end

  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    status      = ffa_pkg::ST_OK;
    granted_ext = 16'd0;
    count_next  = count;
    if (cur.alloc == ffa_pkg::REQ_ALLOC) begin
      if (hit) begin
        do_remove   = 1'b1;
        granted_ext = 16'(granted);
        count_next  = count - CW'(1);
      end else begin
        status = ffa_pkg::ST_NOFIT;
      end
    end else begin
      if (full) begin
        status = ffa_pkg::ST_FULL;
      end else begin
        do_insert  = 1'b1;
        count_next = count + CW'(1);
      end
    end
  end

  assign count_wide = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      exec      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      valid_q   <= '0;
    end else begin
      if (q_pop) begin
        exec <= 1'b1;
      end else if (fire) begin
        exec <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        count     <= count_next;
        if (do_insert) begin
          valid_q <= {valid_q[ENTRIES-2:0], 1'b1};
        end else if (do_remove) begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            if (!below[i]) begin
              valid_q[i] <= valid_q[i+1];
            end
          end
          valid_q[ENTRIES-1] <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_req;
      for (int i = 0; i < ENTRIES; i++) begin
        match[i] <= valid_q[i] && (size_q[i] >= q_req.amount[W-1:0]);
      end
    end
    if (fire) begin
      out_res.status     <= status;
      out_res.granted    <= granted_ext;
      out_res.free_count <= count_wide[4:0];
      if (do_insert) begin
        start_q[0] <= cur.start[W-1:0];
        size_q[0]  <= cur.amount[W-1:0];
        for (int i = 1; i < ENTRIES; i++) begin
          start_q[i] <= start_q[i-1];
          size_q[i]  <= size_q[i-1];
        end
      end else if (do_remove) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          if (!below[i]) begin
            start_q[i] <= start_q[i+1];
            size_q[i]  <= size_q[i+1];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
